// ===== rtl/core/mlt_pkg.sv =====
// ----------------------------------------------------------------------------
// mlt_pkg
// types, codes and hash constants for the mac learning table
// ----------------------------------------------------------------------------
package mlt_pkg;
	localparam int BUCKET_BITS_DEF = 7;
	localparam int WAYS_DEF        = 4;
	localparam int KEY_W  = 60;
	localparam int PORT_W = 8;
	localparam int TIME_W = 32;

	localparam logic [1:0] CMD_LEARN  = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;
	localparam logic [1:0] CMD_FLUSH  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [0:0] REG_MIN_PERSIST = 1'd0;
	localparam logic [0:0] REG_USED_BITS   = 1'd1;

	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int MIX_SHIFT = 33;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [47:0]       mac;
		logic [11:0]       vlan;
		logic [PORT_W-1:0] port;
		logic [TIME_W-1:0] now_secs;
	} req_t;

	typedef struct packed {
		logic [PORT_W-1:0] result_port;
		logic [1:0]        status;
	} rsp_t;
endpackage

// ===== rtl/core/mlt_if.sv =====
// ----------------------------------------------------------------------------
// mlt_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface mlt_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mac_learning_table_unit.sv =====
// ----------------------------------------------------------------------------
// mac_learning_table_unit
// hashed mac+vlan forwarding table with learn, lookup, port purge and flush
// ----------------------------------------------------------------------------
// channel  | dir | payload
// req      | in  | cmd, mac, vlan, port, now_secs
// rsp      | out | result_port, status
// cfg      | in  | wr_en, wr_index, wr_data
//
// learn/lookup: hashing on one shared 32x32 multiplier (two 64-bit products of
// three partial products and a fold each), then a read and a compare state per
// way until a hit or the last way, then the output state.
// delete and flush walk every slot, one per cycle, then go to the output state.
// after reset the same walk clears the slot valid bits while ready is low.
// ready is high only when idle; the output cycle waits while a response is held.
// ----------------------------------------------------------------------------
module mac_learning_table_unit
	import mlt_pkg::*;
#(
	parameter int BUCKET_BITS = BUCKET_BITS_DEF,
	parameter int WAYS        = WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mlt_if.sink         req,
	mlt_if.source       rsp,
	input  logic        wr_en,
	input  logic [0:0]  wr_index,
	input  logic [15:0] wr_data
);
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NSLOTS = (1 << BUCKET_BITS) * WAYS;
	localparam int SLOT_W = $clog2(NSLOTS);
	localparam int WCNT_W = $clog2(WAYS + 1);
	localparam int CNT_W  = SLOT_W + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_WALK = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic        init_q;
	logic [15:0] min_persist_q;
	logic [2:0]  used_bits_q;
	req_t        req_q;
	logic [63:0] h_q;
	logic [63:0] acc_q;
	logic [2:0]  hstep_q;
	logic [WCNT_W-1:0] way_q;
	logic        have_free_q;
	logic [WAY_W-1:0]  free_way_q;
	logic [CNT_W-1:0]  walk_q;
	logic [SLOT_W-1:0] rd_addr_q;
	logic              rd_valid_q;
	logic [KEY_W-1:0]  rd_key_q;
	logic [PORT_W-1:0] rd_port_q;
	logic [TIME_W-1:0] rd_seen_q;
	rsp_t        res_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	logic              mem_valid [NSLOTS];
	logic [KEY_W-1:0]  mem_key  [NSLOTS];
	logic [PORT_W-1:0] mem_port [NSLOTS];
	logic [TIME_W-1:0] mem_seen [NSLOTS];

	logic [KEY_W-1:0]  key;
	logic [BUCKET_BITS-1:0] bucket;
	logic [BUCKET_BITS-1:0] bmask;
	logic [3:0]  ubits;
	logic [63:0] mconst;
	logic [31:0] ma, mb;
	logic [63:0] prod;
	logic [WAY_W-1:0]  way_idx;
	logic [SLOT_W-1:0] base_slot;
	logic [SLOT_W-1:0] way_slot;
	logic [SLOT_W-1:0] rd_addr;
	logic        mem_we;
	logic [SLOT_W-1:0] wr_slot;
	logic        walk_clr;
	logic        clr_we;
	logic        slot_hit;
	logic        rsp_load;

	assign key = {req_q.vlan, req_q.mac};
	assign ubits = (32'(used_bits_q) > BUCKET_BITS) ? 4'(BUCKET_BITS) : {1'b0, used_bits_q};
	always_comb begin
		bmask = '0;
		for (int i = 0; i < BUCKET_BITS; i++)
			bmask[i] = (i < int'(ubits));
	end
	assign bucket    = h_q[BUCKET_BITS-1:0] & bmask;
	assign way_idx   = way_q[WAY_W-1:0];
	assign base_slot = SLOT_W'(bucket) * SLOT_W'(WAYS);
	assign way_slot  = base_slot + SLOT_W'(way_idx);
	assign rd_addr   = (state_q == S_WALK) ? walk_q[SLOT_W-1:0] : way_slot;

	// hstep 0..2 partial products and 3 the fold of first multiply, 4..6 and 7 of second
	assign mconst = hstep_q[2] ? MIX_C2 : MIX_C1;
	always_comb begin
		case (hstep_q[1:0])
			2'd0: begin ma = h_q[31:0];  mb = mconst[31:0];  end
			2'd1: begin ma = h_q[31:0];  mb = mconst[63:32]; end
			2'd2: begin ma = h_q[63:32]; mb = mconst[31:0];  end
			default: begin ma = h_q[31:0]; mb = mconst[31:0]; end
		endcase
	end
	assign prod = ma * mb;

	assign slot_hit = rd_valid_q && (rd_key_q == key);

	// purge clears matching slots, flush and the reset pass clear all
	assign walk_clr = init_q || (req_q.cmd == CMD_FLUSH) ||
		(rd_valid_q && rd_port_q == req_q.port);
	assign clr_we = (state_q == S_WALK) && (walk_q != '0) && walk_clr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_persist_q <= 16'd3;
			used_bits_q   <= 3'd7;
		end else if (wr_en) begin
			case (wr_index)
				REG_MIN_PERSIST: min_persist_q <= wr_data;
				REG_USED_BITS:   used_bits_q   <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_valid_q <= mem_valid[rd_addr];
		rd_key_q   <= mem_key[rd_addr];
		rd_port_q  <= mem_port[rd_addr];
		rd_seen_q  <= mem_seen[rd_addr];
		if (mem_we) begin
			mem_valid[wr_slot] <= 1'b1;
			mem_key[wr_slot]   <= key;
			mem_port[wr_slot]  <= req_q.port;
			mem_seen[wr_slot]  <= req_q.now_secs;
		end else if (clr_we) begin
			mem_valid[rd_addr_q] <= 1'b0;
		end
	end

	always_comb begin
		mem_we  = 1'b0;
		wr_slot = rd_addr_q;
		if (state_q == S_CMP && req_q.cmd == CMD_LEARN) begin
			if (slot_hit) begin
				if (rd_port_q == req_q.port)
					mem_we = 1'b1;
				else if ((req_q.now_secs - rd_seen_q) > {16'd0, min_persist_q})
					mem_we = 1'b1;
			end else if (32'(way_q) == WAYS - 1 && (have_free_q || !rd_valid_q)) begin
				mem_we = 1'b1;
				if (have_free_q)
					wr_slot = base_slot + SLOT_W'(free_way_q);
			end
		end
	end

	assign rsp_load  = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WALK;
			init_q      <= 1'b1;
			walk_q      <= '0;
			rd_addr_q   <= '0;
			req_q       <= '0;
			h_q         <= '0;
			acc_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			hstep_q     <= '0;
			way_q       <= '0;
			have_free_q <= 1'b0;
			free_way_q  <= '0;
		end else begin
			rd_addr_q <= rd_addr;
			if (rsp_load) begin
				rsp_q       <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q   <= req.data;
						res_q   <= '{result_port: '0, status: ST_OK};
						hstep_q <= '0;
						way_q   <= '0;
						walk_q  <= '0;
						have_free_q <= 1'b0;
						h_q <= {4'd0, req.data.vlan, req.data.mac} ^
							({4'd0, req.data.vlan, req.data.mac} >> MIX_SHIFT);
						case (req.data.cmd)
							CMD_LEARN, CMD_LOOKUP: state_q <= S_HASH;
							default: state_q <= S_WALK;
						endcase
					end
				end
				S_HASH: begin
					hstep_q <= hstep_q + 3'd1;
					case (hstep_q[1:0])
						2'd0: acc_q <= prod;
						2'd1: acc_q <= acc_q + {prod[31:0], 32'd0};
						2'd2: acc_q <= acc_q + {prod[31:0], 32'd0};
						default: begin
							h_q <= acc_q ^ (acc_q >> MIX_SHIFT);
							if (hstep_q[2]) begin
								state_q <= S_RD;
							end
						end
					endcase
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (slot_hit) begin
						res_q.result_port <= rd_port_q;
						state_q <= S_OUT;
					end else begin
						if (!rd_valid_q && !have_free_q) begin
							have_free_q <= 1'b1;
							free_way_q  <= way_idx;
						end
						if (32'(way_q) == WAYS - 1) begin
							if (req_q.cmd == CMD_LOOKUP)
								res_q.status <= ST_NOTFOUND;
							else if (mem_we)
								res_q.result_port <= req_q.port;
							else
								res_q.status <= ST_FULL;
							state_q <= S_OUT;
						end else begin
							way_q   <= way_q + WCNT_W'(1);
							state_q <= S_RD;
						end
					end
				end
				S_WALK: begin
					walk_q <= walk_q + CNT_W'(1);
					if (walk_q == CNT_W'(NSLOTS)) begin
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_OUT;
					end
				end
				S_OUT: begin
					if (rsp_load)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== dv/mlt_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_tb_if
// note: the channel interface itself comes from the rtl (mlt_if); this file
// holds the small helper type shared by the testbench
// ----------------------------------------------------------------------------
package mlt_tb_pkg;
	import mlt_pkg::*;

	typedef struct {
		req_t req;
		logic chk;
		rsp_t rsp;
	} stim_row_t;
endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// mac learning table: directed table then random learn/lookup/purge/flush
// traffic with a table predictor, random idling on both channels, a long
// response hold-off, and register changes between phases while idle
// ----------------------------------------------------------------------------
module testbench;
	import mlt_pkg::*;
	import mlt_tb_pkg::*;

	localparam int NB = 1 << BUCKET_BITS_DEF;
	localparam int NS = NB * WAYS_DEF;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [0:0] wr_index = REG_MIN_PERSIST;
	logic [15:0] wr_data = '0;

	mlt_if #(.T(req_t)) req_ch ();
	mlt_if #(.T(rsp_t)) rsp_ch ();

	mac_learning_table_unit u_dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #5 clk = ~clk;

	// table shadow
	logic tbl_valid [NS];
	logic [59:0] tbl_key [NS];
	logic [7:0] tbl_port [NS];
	logic [31:0] tbl_seen [NS];
	logic [15:0] persist_secs;
	logic [2:0] bucket_bits;

	rsp_t pending_rsp [$];
	logic pending_chk [$];
	rsp_t pending_lit [$];
	int fails = 0;
	int idle_cycles = 0;
	bit rsp_hold = 1'b0;
	bit hold_done = 1'b0;

	// recent keys for reuse
	logic [47:0] mac_pool [$];
	logic [11:0] vlan_pool [$];

	function automatic int hash_bucket(logic [59:0] key);
		logic [63:0] h;
		int bits;
		h = {4'd0, key};
		bits = (bucket_bits > BUCKET_BITS_DEF) ? BUCKET_BITS_DEF : bucket_bits;
		h = h ^ (h >> 33);
		h = h * 64'hff51afd7ed558ccd;
		h = h ^ (h >> 33);
		h = h * 64'hc4ceb9fe1a85ec53;
		h = h ^ (h >> 33);
		return int'(h & ((64'd1 << bits) - 1));
	endfunction

	function automatic int find_way(logic [59:0] key, int b);
		for (int w = 0; w < WAYS_DEF; w++)
			if (tbl_valid[b*WAYS_DEF+w] && tbl_key[b*WAYS_DEF+w] == key)
				return b*WAYS_DEF + w;
		return -1;
	endfunction

	function automatic rsp_t table_apply(req_t r);
		rsp_t o;
		logic [59:0] key;
		int b, s, fr;
		o = '0;
		key = {r.vlan, r.mac};
		case (r.cmd)
			CMD_LEARN: begin
				b = hash_bucket(key);
				s = find_way(key, b);
				if (s < 0) begin
					fr = -1;
					for (int w = WAYS_DEF - 1; w >= 0; w--)
						if (!tbl_valid[b*WAYS_DEF+w]) fr = b*WAYS_DEF + w;
					if (fr < 0) begin
						o.status = ST_FULL;
					end else begin
						tbl_valid[fr] = 1'b1;
						tbl_key[fr] = key;
						tbl_port[fr] = r.port;
						tbl_seen[fr] = r.now_secs;
						o.result_port = r.port;
					end
				end else begin
					o.result_port = tbl_port[s];
					if (tbl_port[s] != r.port) begin
						if (32'(r.now_secs - tbl_seen[s]) > {16'd0, persist_secs}) begin
							tbl_port[s] = r.port;
							tbl_seen[s] = r.now_secs;
						end
					end else begin
						tbl_seen[s] = r.now_secs;
					end
				end
			end
			CMD_LOOKUP: begin
				s = find_way(key, hash_bucket(key));
				if (s < 0) o.status = ST_NOTFOUND;
				else o.result_port = tbl_port[s];
			end
			CMD_DELETE: begin
				for (int i = 0; i < NS; i++)
					if (tbl_valid[i] && tbl_port[i] == r.port) tbl_valid[i] = 1'b0;
			end
			default: begin
				for (int i = 0; i < NS; i++) tbl_valid[i] = 1'b0;
			end
		endcase
		return o;
	endfunction

	// request driver
	task automatic send_req(req_t r, logic chk, rsp_t lit);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_rsp.push_back(table_apply(r));
		pending_chk.push_back(chk);
		pending_lit.push_back(lit);
		@(negedge clk);
	endtask

	task automatic drain_and_idle();
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(negedge clk);
		repeat (NS + 40) @(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == REG_MIN_PERSIST) persist_secs = val;
		else bucket_bits = val[2:0];
	endtask

	function automatic req_t mk_req(logic [1:0] c, logic [47:0] m, logic [11:0] v,
			logic [7:0] p, logic [31:0] t);
		req_t r;
		r.cmd = c; r.mac = m; r.vlan = v; r.port = p; r.now_secs = t;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(logic [7:0] p, logic [1:0] s);
		rsp_t o;
		o.result_port = p; o.status = s;
		return o;
	endfunction

	task automatic random_phase(int n, int key_span, int port_span);
		req_t r;
		int k;
		for (int i = 0; i < n; i++) begin
			k = int'($urandom_range(0, 99));
			r.cmd = (k < 55) ? CMD_LEARN : (k < 95) ? CMD_LOOKUP :
				(k < 99) ? CMD_DELETE : CMD_FLUSH;
			if (mac_pool.size() != 0 && $urandom_range(0, 2) != 0) begin
				k = int'($urandom_range(0, mac_pool.size() - 1));
				r.mac = mac_pool[k];
				r.vlan = vlan_pool[k];
			end else begin
				r.mac = 48'({$urandom, $urandom});
				r.vlan = 12'($urandom);
				if (key_span > 0) begin
					r.mac = 48'($urandom_range(0, key_span));
					r.vlan = 12'($urandom_range(0, 1));
				end
				mac_pool.push_back(r.mac);
				vlan_pool.push_back(r.vlan);
				if (mac_pool.size() > 48) begin
					void'(mac_pool.pop_front());
					void'(vlan_pool.pop_front());
				end
			end
			r.port = 8'((port_span > 0) ? $urandom_range(0, port_span) : $urandom);
			r.now_secs = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
			send_req(r, 1'b0, '0);
		end
	endtask

	// response sink and checker
	initial begin
		int gap;
		rsp_t exp_r;
		logic chk;
		rsp_t lit;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold && !hold_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (600) @(negedge clk);
				hold_done = 1'b1;
			end
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
			if (gap != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			if (pending_rsp.size() == 0) begin
				$error("response with no request outstanding");
				fails++;
			end else begin
				exp_r = pending_rsp.pop_front();
				chk = pending_chk.pop_front();
				lit = pending_lit.pop_front();
				if (chk) exp_r = lit;
				if (rsp_ch.data.result_port !== exp_r.result_port) begin
					$error("result_port expected %0d got %0d", exp_r.result_port,
						rsp_ch.data.result_port);
					fails++;
				end
				if (rsp_ch.data.status !== exp_r.status) begin
					$error("status expected %0d got %0d", exp_r.status, rsp_ch.data.status);
					fails++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	stim_row_t dir_rows [$];

	initial begin
		stim_row_t row;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		for (int i = 0; i < NS; i++) tbl_valid[i] = 1'b0;
		persist_secs = 16'd3;
		bucket_bits = 3'd7;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		dir_rows.push_back('{mk_req(CMD_LOOKUP, '1, '1, 8'd0, 0), 1, mk_rsp(0, ST_NOTFOUND)});
		dir_rows.push_back('{mk_req(CMD_LEARN, '1, '1, 8'hff, '1), 1, mk_rsp(8'hff, ST_OK)});
		dir_rows.push_back('{mk_req(CMD_LOOKUP, '1, '1, 8'd0, 0), 1, mk_rsp(8'hff, ST_OK)});
		dir_rows.push_back('{mk_req(CMD_LEARN, '0, '0, 8'd0, 0), 1, mk_rsp(0, ST_OK)});
		dir_rows.push_back('{mk_req(CMD_LEARN, '0, '0, 8'd5, 3), 1, mk_rsp(0, ST_OK)});
		dir_rows.push_back('{mk_req(CMD_LEARN, '0, '0, 8'd5, 4), 0, '0});
		dir_rows.push_back('{mk_req(CMD_LOOKUP, '0, '0, 8'd0, 4), 0, '0});
		dir_rows.push_back('{mk_req(CMD_LEARN, '1, '1, 8'd7, 2), 0, '0});
		dir_rows.push_back('{mk_req(CMD_LOOKUP, '1, '1, 8'd0, 0), 0, '0});
		dir_rows.push_back('{mk_req(CMD_LEARN, 48'haaaa_5555_aaaa, 12'h555, 8'h55, 0), 0, '0});
		dir_rows.push_back('{mk_req(CMD_DELETE, '0, '0, 8'h55, 0), 1, mk_rsp(0, ST_OK)});
		dir_rows.push_back('{mk_req(CMD_LOOKUP, 48'haaaa_5555_aaaa, 12'h555, 0, 0), 1,
			mk_rsp(0, ST_NOTFOUND)});
		dir_rows.push_back('{mk_req(CMD_FLUSH, '0, '0, 8'd0, 0), 1, mk_rsp(0, ST_OK)});
		dir_rows.push_back('{mk_req(CMD_LOOKUP, '1, '1, 8'd0, 0), 1, mk_rsp(0, ST_NOTFOUND)});
		foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].rsp);
		drain_and_idle();

		// bucket full with a single bucket
		write_reg(REG_USED_BITS, 16'd0);
		write_reg(REG_MIN_PERSIST, 16'd0);
		for (int i = 0; i < WAYS_DEF + 2; i++) begin
			row.req = mk_req(CMD_LEARN, 48'(i), 12'd1, 8'(i + 1), 0);
			row.chk = (i >= WAYS_DEF);
			row.rsp = mk_rsp(0, ST_FULL);
			send_req(row.req, row.chk, row.rsp);
		end
		random_phase(150, 10, 7);
		send_req(mk_req(CMD_FLUSH, 0, 0, 0, 0), 1'b1, mk_rsp(0, ST_OK));
		drain_and_idle();

		write_reg(REG_USED_BITS, 16'd2);
		write_reg(REG_MIN_PERSIST, 16'hffff);
		random_phase(250, 60, 15);
		send_req(mk_req(CMD_FLUSH, 0, 0, 0, 0), 1'b1, mk_rsp(0, ST_OK));
		drain_and_idle();

		write_reg(REG_USED_BITS, 16'd7);
		write_reg(REG_MIN_PERSIST, 16'd5);
		rsp_hold = 1'b1;
		random_phase(400, 0, 0);
		drain_and_idle();

		// bucket bits changed without flush
		write_reg(REG_USED_BITS, 16'd4);
		write_reg(REG_MIN_PERSIST, 16'd1);
		random_phase(320, 200, 31);
		drain_and_idle();

		if (fails == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end
endmodule
